>>> rtl/ffa_pkg.sv
// shared types and codes for the first-fit heap allocator
// no dependencies; imported by ffa_seq and first_fit_heap_allocator
package ffa_pkg;

    localparam int REQ_W  = 13;
    localparam int ADDR_W = 12;
    localparam int STAT_W = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_ALLOC_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ALLOC_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FREED      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORED    = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] address;
    } t_result;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator with forward coalescing
// depends on ffa_pkg, ffa_hdr_mem and ffa_seq
//
// usage:
//   slave channel (i_s_*) takes one command word: tuser is the command
//   (alloc or free), tdata carries request_size and payload_address.
//   master channel (o_m_*) returns exactly one result word per command:
//   tuser is the status, tdata the payload address of an allocated block.
// sequencing: one command at a time; each header visit reads a header word
// from the ram and then evaluates the returned word:
//   allocate: first fitting free header, split when room is left; refused at
//   heap end. free: the matching header merges free neighbours forward up to
//   heap end or a used one; unmatched free ignored; zero size or null: no walk
//   the reply word turns valid in the same cycle as the input turns ready
// reset:
//   synchronous, active low. the heap becomes one free block spanning the
//   whole heap; no clearing pass is needed, input is ready the next cycle.
// back-pressure:
//   a result sits in the output register until taken; the sequencer may
//   finish the next command meanwhile and then waits until the register frees.
module first_fit_heap_allocator
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [12:0] request_size, [24:13] payload_address, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] command
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [11:0] address, [15:12] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [STAT_W-1:0]      o_m_tuser
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int SW = AW;
    localparam int DW = SW + 1;
    // reset header word: free, size covering the heap minus one header
    localparam logic [DW-1:0] INIT_WORD = {1'b1, SW'(HEAP_BYTES - HEADER_BYTES)};

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] rd_data, wr_data;

    logic    res_valid, res_ready;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    ffa_hdr_mem #(
        .DEPTH(HEAP_BYTES),
        .AW(AW),
        .DW(DW),
        .INIT_WORD(INIT_WORD)
    ) u_mem (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en(wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    ffa_seq #(
        .HEAP_BYTES(HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_s_tvalid),
        .o_in_ready(o_s_tready),
        .i_cmd(i_s_tuser),
        .i_req(i_s_tdata[REQ_W-1:0]),
        .i_addr(i_s_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res(res),
        .o_rd_en(rd_en),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_wr_en(wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    // output register: free, or emptied by the receiver this cycle
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - ADDR_W)'(0), r_out.address};
    assign o_m_tuser  = r_out.status;

endmodule

>>> rtl/ffa_hdr_mem.sv
// header store: one synchronous ram word per heap byte address, registered read
// entry 0 reads as its reset word until first written; no package dependency
module ffa_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW = 12,
    parameter int DW = 13,
    parameter logic [DW-1:0] INIT_WORD = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic          r_init;
    logic          r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entry 0 holds the reset word until its first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= 1'b1;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en && (i_wr_addr == '0)) begin
                r_init <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init && (i_rd_addr == '0);
            end
        end
    end

    assign o_rd_data = r_rd_init ? INIT_WORD : r_rd_data;

endmodule

>>> rtl/ffa_seq.sv
// sequencer: walks the header chain, splits on allocate, merges forward on free
// depends on ffa_pkg; drives the header store ports
module ffa_seq
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [REQ_W-1:0]  i_req,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output logic              o_rd_en,
    output logic [$clog2(HEAP_BYTES)-1:0] o_rd_addr,
    input  logic [$clog2(HEAP_BYTES):0]   i_rd_data,
    output logic              o_wr_en,
    output logic [$clog2(HEAP_BYTES)-1:0] o_wr_addr,
    output logic [$clog2(HEAP_BYTES):0]   o_wr_data
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int SW = AW;
    localparam int PW = AW + 1;
    localparam int CW = ((PW > REQ_W) ? PW : REQ_W) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A_RD = 4'd1;
    localparam logic [3:0] S_A_EV = 4'd2;
    localparam logic [3:0] S_A_WR = 4'd3;
    localparam logic [3:0] S_F_RD = 4'd4;
    localparam logic [3:0] S_F_EV = 4'd5;
    localparam logic [3:0] S_M_NX = 4'd6;
    localparam logic [3:0] S_M_EV = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [PW-1:0]     r_pos, n_pos;
    logic [SW-1:0]     r_size, n_size;
    t_result           r_res, n_res;

    logic          rd_free;
    logic [SW-1:0] rd_size;
    logic [CW-1:0] pos_c, hdr_c, heap_c, payload_c, split_c, nxt_c;
    logic [PW-1:0] next_walk;
    logic [SW-1:0] left, left_rem, merged;
    logic          pos_end, fit, do_split, is_target, nxt_in;

    assign rd_free = i_rd_data[SW];
    assign rd_size = i_rd_data[SW-1:0];

    assign pos_c     = CW'(r_pos);
    assign hdr_c     = CW'(HEADER_BYTES);
    assign heap_c    = CW'(HEAP_BYTES);
    assign payload_c = pos_c + hdr_c;
    assign pos_end   = (pos_c >= heap_c);
    assign next_walk = r_pos + PW'(HEADER_BYTES) + PW'(rd_size);

    // allocate: fit test and split
    assign fit      = rd_free && (CW'(rd_size) >= CW'(r_req));
    assign left     = rd_size - SW'(r_req);
    assign left_rem = left - SW'(HEADER_BYTES);
    assign split_c  = payload_c + CW'(r_req);
    assign do_split = (CW'(left) > hdr_c) && (split_c < heap_c);

    // free: target match and forward merge
    assign is_target = (payload_c == CW'(r_addr));
    assign nxt_c     = payload_c + CW'(r_size);
    assign nxt_in    = (nxt_c < heap_c);
    assign merged    = r_size + SW'(HEADER_BYTES) + rd_size;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_size    = r_size;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = r_pos[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_pos[AW-1:0];
        o_wr_data = {1'b0, rd_size};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_req;
                    n_addr = i_addr;
                    n_pos = '0;
                    if (i_cmd == CMD_ALLOC) begin
                        if (i_req == '0) begin
                            n_res = '{status: STAT_ALLOC_FAIL, address: '0};
                            n_state = S_DONE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        if (i_addr == '0) begin
                            n_res = '{status: STAT_IGNORED, address: '0};
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                if (pos_end) begin
                    n_res = '{status: STAT_ALLOC_FAIL, address: '0};
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_A_EV;
                end
            end
            S_A_EV: begin
                if (fit) begin
                    n_res = '{status: STAT_ALLOC_OK, address: payload_c[ADDR_W-1:0]};
                    o_wr_en = 1'b1;
                    if (do_split) begin
                        // new free header after the request, then shrink this one
                        o_wr_addr = split_c[AW-1:0];
                        o_wr_data = {1'b1, left_rem};
                        n_state = S_A_WR;
                    end else begin
                        o_wr_data = {1'b0, rd_size};
                        n_state = S_DONE;
                    end
                end else begin
                    n_pos = next_walk;
                    n_state = S_A_RD;
                end
            end
            S_A_WR: begin
                o_wr_en = 1'b1;
                o_wr_data = {1'b0, SW'(r_req)};
                n_state = S_DONE;
            end
            S_F_RD: begin
                if (pos_end) begin
                    n_res = '{status: STAT_IGNORED, address: '0};
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_F_EV;
                end
            end
            S_F_EV: begin
                if (is_target) begin
                    n_size = rd_size;
                    n_state = S_M_NX;
                end else begin
                    n_pos = next_walk;
                    n_state = S_F_RD;
                end
            end
            S_M_NX: begin
                if (nxt_in) begin
                    o_rd_en = 1'b1;
                    o_rd_addr = nxt_c[AW-1:0];
                    n_state = S_M_EV;
                end else begin
                    o_wr_en = 1'b1;
                    o_wr_data = {1'b1, r_size};
                    n_res = '{status: STAT_FREED, address: '0};
                    n_state = S_DONE;
                end
            end
            S_M_EV: begin
                if (rd_free) begin
                    n_size = merged;
                    n_state = S_M_NX;
                end else begin
                    o_wr_en = 1'b1;
                    o_wr_data = {1'b1, r_size};
                    n_res = '{status: STAT_FREED, address: '0};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_addr <= n_addr;
        r_pos  <= n_pos;
        r_size <= n_size;
        r_res  <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
